>>> rtl/assert_macros.svh
// Assertion macros for the RTL modules; only ffa_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FFA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define FFA_ASSERT_R(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) else $error("reset check failed");
`else
`define FFA_ASSERT(lbl, clk, rst, prop)
`define FFA_ASSERT_R(lbl, clk, prop)
`endif
`endif

>>> rtl/ffa_pkg.sv
// Shared types and constants of the first-fit heap allocator.
package ffa_pkg;

   localparam int GRANULE_SHIFT = 4;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_NO_SPACE = 3'd1;
   localparam logic [2:0] STATUS_BAD_SIZE = 3'd2;
   localparam logic [2:0] STATUS_RANGE    = 3'd3;
   localparam logic [2:0] STATUS_DOUBLE   = 3'd4;
   localparam logic [2:0] STATUS_NULL     = 3'd5;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [23:0] size_bytes;
      logic [31:0] free_addr;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] alloc_addr;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_A_START,
      ST_A_LOAD,
      ST_A_CHECK,
      ST_A_NEXT,
      ST_A_SPLIT,
      ST_A_COMMIT,
      ST_F_CHECK,
      ST_F_UPDATE,
      ST_DONE
   } ffa_state_type;

endpackage

>>> rtl/ffa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ffa_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ffa_ctrl.sv
// Request sequencer: header walk, merge, split, free and result register.
`include "assert_macros.svh"
module ffa_ctrl #(
   parameter int ARENA_GRANULES = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [31:0]                       arena_base,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ffa_pkg::req_item_type             req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ffa_pkg::rsp_item_type             rsp_item,
   output logic                              ram_wr_en,
   output logic [$clog2(ARENA_GRANULES)-1:0] ram_wr_addr,
   output logic [$clog2(ARENA_GRANULES):0]   ram_wr_data,
   output logic                              ram_rd_en,
   output logic [$clog2(ARENA_GRANULES)-1:0] ram_rd_addr,
   input  logic [$clog2(ARENA_GRANULES):0]   ram_rd_data
);
   import ffa_pkg::*;

   localparam int GW = $clog2(ARENA_GRANULES);
   localparam logic [32:0] ARENA_BYTES = 33'(ARENA_GRANULES) << GRANULE_SHIFT;
   localparam logic [GW+1:0] TOTAL = (GW+2)'(ARENA_GRANULES);
   localparam logic [GW+1:0] STEP_LIMIT = (GW+2)'(2 * ARENA_GRANULES);

   ffa_state_type state_ff, state_in;
   req_item_type  req_ff, req_in;
   logic [GW-1:0] n_ff, n_in;
   logic [GW-1:0] cur_size_ff, cur_size_in;
   logic          cur_free_ff, cur_free_in;
   logic [GW:0]   need_ff, need_in;
   logic [GW+1:0] steps_ff, steps_in;
   logic [2:0]    res_status_ff, res_status_in;
   logic [31:0]   res_addr_ff, res_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_item_ff, rsp_item_in;

   logic [GW-1:0] nx_size;
   logic          nx_free;
   logic [GW+1:0] next_w, steps_inc, merge_end, rest_w;
   logic [GW:0]   merged_w;
   logic          fits, do_split;
   logic [24:0]   round_w;
   logic [32:0]   a33, lo33, hi33;
   logic [31:0]   diff_w;
   logic [GW-1:0] g_w;
   logic [31:0]   data_addr;

   assign nx_size   = ram_rd_data[GW-1:0];
   assign nx_free   = ram_rd_data[GW];
   assign next_w    = (GW+2)'(n_ff) + (GW+2)'(1) + (GW+2)'(cur_size_ff);
   assign steps_inc = steps_ff + (GW+2)'(1);
   assign merged_w  = (GW+1)'(cur_size_ff) + (GW+1)'(nx_size) + (GW+1)'(1);
   assign merge_end = (GW+2)'(n_ff) + (GW+2)'(1) + (GW+2)'(merged_w);
   assign rest_w    = (GW+2)'(n_ff) + (GW+2)'(1) + (GW+2)'(need_ff);
   assign fits      = cur_free_ff && ((GW+1)'(cur_size_ff) >= need_ff);
   assign do_split  = (GW+2)'(cur_size_ff) > ((GW+2)'(need_ff) + (GW+2)'(1));
   assign round_w   = 25'(req_ff.size_bytes) + 25'd15;
   assign a33       = {1'b0, req_ff.free_addr};
   assign lo33      = {1'b0, arena_base};
   assign hi33      = lo33 + ARENA_BYTES;
   assign diff_w    = req_ff.free_addr - arena_base;
   assign g_w       = diff_w[GW+3:4];
   assign data_addr = arena_base + ((32'(n_ff) + 32'd1) << GRANULE_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      n_ff          <= n_in;
      cur_size_ff   <= cur_size_in;
      cur_free_ff   <= cur_free_in;
      need_ff       <= need_in;
      steps_ff      <= steps_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_item_ff   <= rsp_item_in;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      n_in          = n_ff;
      cur_size_in   = cur_size_ff;
      cur_free_in   = cur_free_ff;
      need_in       = need_ff;
      steps_in      = steps_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_item_in   = rsp_item_ff;
      req_ready     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = n_ff;
      ram_wr_data   = {cur_free_ff, cur_size_ff};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = n_ff;
      case (state_ff)
         ST_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            ram_wr_data = {1'b1, GW'(ARENA_GRANULES - 1)};
            state_in    = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_item;
               state_in = (req_item.req_type == REQ_FREE) ? ST_F_CHECK : ST_A_START;
            end
         end
         ST_A_START: begin
            res_addr_in = '0;
            if (req_ff.size_bytes == 24'd0 || 33'(req_ff.size_bytes) >= ARENA_BYTES) begin
               res_status_in = STATUS_BAD_SIZE;
               state_in      = ST_DONE;
            end else begin
               need_in     = round_w[GW+4:4];
               n_in        = '0;
               steps_in    = '0;
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               state_in    = ST_A_LOAD;
            end
         end
         ST_A_LOAD: begin
            cur_size_in = nx_size;
            cur_free_in = nx_free;
            state_in    = ST_A_CHECK;
         end
         ST_A_CHECK: begin
            if (fits) begin
               if (do_split && rest_w < TOTAL) begin
                  state_in = ST_A_SPLIT;
               end else begin
                  state_in = ST_A_COMMIT;
               end
            end else if (next_w >= TOTAL || steps_inc > STEP_LIMIT) begin
               res_status_in = STATUS_NO_SPACE;
               state_in      = ST_DONE;
            end else begin
               steps_in    = steps_inc;
               ram_rd_en   = 1'b1;
               ram_rd_addr = next_w[GW-1:0];
               state_in    = ST_A_NEXT;
            end
         end
         ST_A_NEXT: begin
            if (cur_free_ff && nx_free) begin
               if (merge_end > TOTAL) begin
                  res_status_in = STATUS_NO_SPACE;
                  state_in      = ST_DONE;
               end else begin
                  cur_size_in = merged_w[GW-1:0];
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {1'b1, merged_w[GW-1:0]};
                  state_in    = ST_A_CHECK;
               end
            end else begin
               n_in        = next_w[GW-1:0];
               cur_size_in = nx_size;
               cur_free_in = nx_free;
               state_in    = ST_A_CHECK;
            end
         end
         ST_A_SPLIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = rest_w[GW-1:0];
            ram_wr_data = {1'b1, GW'((GW+1)'(cur_size_ff) - need_ff - (GW+1)'(1))};
            cur_size_in = need_ff[GW-1:0];
            state_in    = ST_A_COMMIT;
         end
         ST_A_COMMIT: begin
            ram_wr_en     = 1'b1;
            ram_wr_data   = {1'b0, cur_size_ff};
            res_status_in = STATUS_OK;
            res_addr_in   = data_addr;
            state_in      = ST_DONE;
         end
         ST_F_CHECK: begin
            res_addr_in = '0;
            if (req_ff.free_addr == 32'd0) begin
               res_status_in = STATUS_NULL;
               state_in      = ST_DONE;
            end else if (a33 < lo33 || a33 >= hi33 || g_w == '0) begin
               res_status_in = STATUS_RANGE;
               state_in      = ST_DONE;
            end else begin
               n_in        = g_w - GW'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = g_w - GW'(1);
               state_in    = ST_F_UPDATE;
            end
         end
         ST_F_UPDATE: begin
            if (nx_free) begin
               res_status_in = STATUS_DOUBLE;
            end else begin
               ram_wr_en     = 1'b1;
               ram_wr_data   = {1'b1, nx_size};
               res_status_in = STATUS_OK;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_item_in.status     = res_status_ff;
               rsp_item_in.alloc_addr = res_addr_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `FFA_ASSERT(no_rw_collision, clock, reset, !(ram_wr_en && ram_rd_en && ram_wr_addr == ram_rd_addr))
   `FFA_ASSERT(error_has_no_addr, clock, reset, rsp_valid |-> (rsp_item.status == STATUS_OK || rsp_item.alloc_addr == 32'd0))
   `FFA_ASSERT(accept_starts_work, clock, reset, (req_valid && req_ready) |=> (state_ff == ST_A_START || state_ff == ST_F_CHECK))
   `FFA_ASSERT_R(reset_inits_head, clock, reset |=> state_ff == ST_INIT)

endmodule

>>> rtl/first_fit_heap_allocator_core.sv
// First-fit heap allocator: top level with the arena base register and header memory.
// Allocate walks block headers from granule 0, one memory read per visited header, and
// merges adjacent free blocks on the way; a free reads only the header of its block, and a
// request rejected before any walk reads none. After reset the head header is written before
// the first item is taken. Each item gives exactly one result item, held in an output register.
module first_fit_heap_allocator_core #(
   parameter int ARENA_GRANULES = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [31:0]           csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ffa_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ffa_pkg::rsp_item_type rsp_item
);
   import ffa_pkg::*;

   localparam int GW = $clog2(ARENA_GRANULES);

   logic [31:0]   arena_base_ff;
   logic          ram_wr_en, ram_rd_en;
   logic [GW-1:0] ram_wr_addr, ram_rd_addr;
   logic [GW:0]   ram_wr_data, ram_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_base_ff <= '0;
      end else if (csr_valid) begin
         arena_base_ff <= csr_wdata;
      end
   end

   ffa_ram #(.WIDTH(GW + 1), .DEPTH(ARENA_GRANULES)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ffa_ctrl #(.ARENA_GRANULES(ARENA_GRANULES)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .arena_base  (arena_base_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

endmodule
